### rtl/core/ffha_pkg.sv
// shared constants and types for the first-fit heap allocator
package ffha_pkg;
  localparam int HeapWords   = 4096;
  localparam int AddrW       = 12;
  localparam int SizeW       = 13;
  localparam int HeaderWords = 3;
  localparam int WordBytes   = 8;
  localparam int MinHeap     = 8;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO     = 2'd1,
    ST_NOMEM    = 2'd2,
    ST_BADPTR   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_AREAD, S_ACHK, S_FREAD, S_FCHK, S_NREAD, S_NCHK,
    S_PREAD, S_PCHK, S_DONE
  } state_t;

  // one header: size, next link, free mark
  typedef struct packed {
    logic [SizeW-1:0] size;
    logic [AddrW-1:0] next;
    logic             free;
  } hdr_t;
endpackage

### rtl/core/first_fit_heap_allocator.sv
// first-fit heap allocator with split and coalesce over a header memory
// Headers live in one 4096-entry synchronous memory with a registered read.
// Allocate walks the block chain, reading (S_AREAD) and checking (S_ACHK)
// each header, then writes the split header; free walks the chain in the
// same manner until the block is found, then merges it with its free
// neighbors, reading and checking the next header and then the previous
// one. A zero-size allocate goes straight to its result. Only one item is
// in work at a time, and a result held by out_stall also holds off the
// next input beat. Headers off the chain are never read, so the memory
// needs no clearing pass; reset and a heap_words write just rewrite
// header 0.
module first_fit_heap_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [12:0] cfg_heap_words,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [15:0] in_request_bytes,
  input  logic [11:0] in_block_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_user_addr,
  output logic [1:0]  out_status
);
  localparam int AW = ffha_pkg::AddrW;
  localparam int SW = ffha_pkg::SizeW;

  ffha_pkg::hdr_t mem [ffha_pkg::HeapWords];
  ffha_pkg::hdr_t rd_q;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  ffha_pkg::hdr_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  ffha_pkg::state_t state_r, state_nxt;
  logic [SW-1:0] heap_r;
  logic [AW-1:0] last_r, last_nxt;
  logic [AW-1:0] h_r, h_nxt, prev_r, prev_nxt;
  logic          has_prev_r, has_prev_nxt;
  // one bit wider than a size: the largest request rounds up to 8192 words
  logic [SW:0]   words_r, words_nxt;
  logic [AW-1:0] baddr_r;
  logic          op_r;
  ffha_pkg::hdr_t o_r, o_nxt;
  logic          ov_r;
  logic [AW-1:0] oaddr_r, oaddr_nxt;
  ffha_pkg::status_t ost_r, ost_nxt;
  logic          done;

  // clamp the written heap size
  logic [SW-1:0] cfg_clamped;
  always_comb begin
    cfg_clamped = cfg_heap_words;
    if (cfg_heap_words < SW'(ffha_pkg::MinHeap)) cfg_clamped = SW'(ffha_pkg::MinHeap);
    if (cfg_heap_words > SW'(ffha_pkg::HeapWords)) cfg_clamped = SW'(ffha_pkg::HeapWords);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_r <= SW'(ffha_pkg::HeapWords);
    end else if (cfg_we) begin
      heap_r <= cfg_clamped;
    end
  end

  assign in_stall = (state_r != ffha_pkg::S_IDLE) || (ov_r && out_stall) || cfg_we;
  logic acc;
  assign acc = in_valid && !in_stall;

  // helpers on the freshly read header
  logic [SW-1:0] rem;
  logic [AW:0]   split_at;
  logic [SW+1:0] merged;
  logic          fits;
  assign fits     = rd_q.free && ({1'b0, rd_q.size} >= words_r);
  assign rem      = rd_q.size - words_r[SW-1:0];
  assign split_at = {1'b0, h_r} + (AW+1)'(ffha_pkg::HeaderWords) + (AW+1)'(words_r);
  assign merged   = (SW+2)'(o_r.size) + (SW+2)'(rd_q.size) + (SW+2)'(ffha_pkg::HeaderWords);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffha_pkg::S_INIT: state_nxt = ffha_pkg::S_IDLE;
      ffha_pkg::S_IDLE: begin
        if (cfg_we) state_nxt = ffha_pkg::S_INIT;
        else if (acc) begin
          if (in_op) state_nxt = ffha_pkg::S_FREAD;
          else if (in_request_bytes == '0) state_nxt = ffha_pkg::S_DONE;
          else state_nxt = ffha_pkg::S_AREAD;
        end
      end
      ffha_pkg::S_AREAD: state_nxt = ffha_pkg::S_ACHK;
      ffha_pkg::S_ACHK: begin
        if (fits || rd_q.next == '0)
          state_nxt = ffha_pkg::S_DONE;
        else state_nxt = ffha_pkg::S_AREAD;
      end
      ffha_pkg::S_FREAD: state_nxt = ffha_pkg::S_FCHK;
      ffha_pkg::S_FCHK: begin
        if ((AW+1)'(h_r) + (AW+1)'(ffha_pkg::HeaderWords) == {1'b0, baddr_r}) begin
          if (rd_q.free) state_nxt = ffha_pkg::S_DONE;
          else if (rd_q.next != '0) state_nxt = ffha_pkg::S_NREAD;
          else if (has_prev_r) state_nxt = ffha_pkg::S_PREAD;
          else state_nxt = ffha_pkg::S_DONE;
        end else if (rd_q.next == '0) state_nxt = ffha_pkg::S_DONE;
        else state_nxt = ffha_pkg::S_FREAD;
      end
      ffha_pkg::S_NREAD: state_nxt = ffha_pkg::S_NCHK;
      ffha_pkg::S_NCHK:
        state_nxt = has_prev_r ? ffha_pkg::S_PREAD : ffha_pkg::S_DONE;
      ffha_pkg::S_PREAD: state_nxt = ffha_pkg::S_PCHK;
      ffha_pkg::S_PCHK: state_nxt = ffha_pkg::S_DONE;
      ffha_pkg::S_DONE: state_nxt = ffha_pkg::S_IDLE;
      default: state_nxt = ffha_pkg::S_INIT;
    endcase
  end

  // datapath and memory control
  always_comb begin
    rd_addr = h_r;
    wr_en = 1'b0;
    wr_addr = h_r;
    wr_data = rd_q;
    h_nxt = h_r;
    prev_nxt = prev_r;
    has_prev_nxt = has_prev_r;
    words_nxt = words_r;
    last_nxt = last_r;
    o_nxt = o_r;
    oaddr_nxt = '0;
    ost_nxt = ost_r;
    done = 1'b0;
    case (state_r)
      ffha_pkg::S_INIT: begin
        wr_en = 1'b1;
        wr_addr = '0;
        wr_data.size = heap_r - SW'(ffha_pkg::HeaderWords);
        wr_data.next = '0;
        wr_data.free = 1'b1;
        last_nxt = '0;
      end
      ffha_pkg::S_IDLE: begin
        rd_addr = '0;
        h_nxt = '0;
        has_prev_nxt = 1'b0;
        prev_nxt = '0;
        words_nxt = (SW+1)'((17'(in_request_bytes) + 17'(ffha_pkg::WordBytes - 1))
                            >> $clog2(ffha_pkg::WordBytes));
        ost_nxt = (!in_op && in_request_bytes == '0) ? ffha_pkg::ST_ZERO : ffha_pkg::ST_OK;
      end
      ffha_pkg::S_ACHK: begin
        if (fits) begin
          wr_en = 1'b1;
          wr_data.free = 1'b0;
          ost_nxt = ffha_pkg::ST_OK;
          oaddr_nxt = h_r + AW'(ffha_pkg::HeaderWords);
          if (rem > SW'(ffha_pkg::HeaderWords + 1) && !split_at[AW]) begin
            wr_data.size = words_r[SW-1:0];
            wr_data.next = split_at[AW-1:0];
            o_nxt.size = rem - SW'(ffha_pkg::HeaderWords);
            o_nxt.next = rd_q.next;
            o_nxt.free = 1'b1;
            if (last_r == h_r) last_nxt = split_at[AW-1:0];
          end
        end else if (rd_q.next == '0) begin
          ost_nxt = ffha_pkg::ST_NOMEM;
        end else begin
          h_nxt = rd_q.next;
        end
      end
      ffha_pkg::S_FCHK: begin
        o_nxt = rd_q;
        if ((AW+1)'(h_r) + (AW+1)'(ffha_pkg::HeaderWords) == {1'b0, baddr_r}) begin
          if (rd_q.free) ost_nxt = ffha_pkg::ST_BADPTR;
          else ost_nxt = ffha_pkg::ST_OK;
          rd_addr = rd_q.next;
          if (!rd_q.free && rd_q.next == '0) begin
            rd_addr = prev_r;
            if (!has_prev_r) begin
              wr_en = 1'b1;
              wr_data.free = 1'b1;
            end
          end
        end else if (rd_q.next == '0) begin
          ost_nxt = ffha_pkg::ST_BADPTR;
        end else begin
          prev_nxt = h_r;
          has_prev_nxt = 1'b1;
          h_nxt = rd_q.next;
          rd_addr = rd_q.next;
        end
      end
      ffha_pkg::S_FREAD: rd_addr = h_r;
      ffha_pkg::S_NREAD: rd_addr = o_r.next;
      ffha_pkg::S_NCHK: begin
        // merge with the following block when it is free
        if (rd_q.free) begin
          if (last_r == o_r.next) last_nxt = h_r;
          o_nxt.size = SW'(merged);
          o_nxt.next = rd_q.next;
        end
        if (!has_prev_r) begin
          wr_en = 1'b1;
          wr_data = o_nxt;
          wr_data.free = 1'b1;
        end
        rd_addr = prev_r;
      end
      ffha_pkg::S_PREAD: rd_addr = prev_r;
      ffha_pkg::S_PCHK: begin
        wr_en = 1'b1;
        if (rd_q.free) begin
          if (last_r == h_r) last_nxt = prev_r;
          wr_addr = prev_r;
          wr_data.size = SW'(merged);
          wr_data.next = o_r.next;
          wr_data.free = 1'b1;
        end else begin
          wr_addr = h_r;
          wr_data = o_r;
          wr_data.free = 1'b1;
        end
      end
      ffha_pkg::S_DONE: begin
        done = 1'b1;
        // finish an allocate split by writing the new free header
        if (!op_r && ost_r == ffha_pkg::ST_OK && o_r.free) begin
          wr_en = 1'b1;
          wr_addr = h_r + AW'(ffha_pkg::HeaderWords) + AW'(words_r);
          wr_data = o_r;
        end
      end
      default: ;
    endcase
  end

  logic [AW-1:0] oaddr_hold_r;
  always_ff @(posedge clk) begin
    h_r <= h_nxt;
    prev_r <= prev_nxt;
    has_prev_r <= has_prev_nxt;
    words_r <= words_nxt;
    if (state_r == ffha_pkg::S_IDLE) begin
      baddr_r <= in_block_addr;
      op_r <= in_op;
      o_r <= '0;
      oaddr_hold_r <= '0;
    end else begin
      o_r <= o_nxt;
      if (state_r == ffha_pkg::S_ACHK) oaddr_hold_r <= oaddr_nxt;
    end
    ost_r <= ost_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffha_pkg::S_INIT;
      last_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r <= last_nxt;
      if (done) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_status <= ost_r;
      out_user_addr <= (!op_r && ost_r == ffha_pkg::ST_OK) ? oaddr_hold_r : '0;
    end
  end

  assign out_valid = ov_r;
endmodule

### rtl/core/ffha_checker.sv
// port-level checks for the first-fit heap allocator
module ffha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] out_user_addr,
  input logic [1:0]  out_status
);
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ffha_pkg::ST_OK |-> out_user_addr == '0)
    else $error("addr on failure");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("second beat while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)) else $error("result dropped");
endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);
